// ----- design/qbp_pkg.sv -----
package qbp_pkg;

	localparam int SAMPLE_WIDTH = 8;
	localparam int BYTE_BITS    = 8;
	localparam int KEPT_WIDTH   = 4;
	localparam int FILL_WIDTH   = $clog2(BYTE_BITS);
	localparam int FIFO_DEPTH   = 4;
	localparam int PTR_WIDTH    = $clog2(FIFO_DEPTH);
	localparam int CNT_WIDTH    = PTR_WIDTH + 1;

	localparam logic [KEPT_WIDTH-1:0] KEPT_RESET = KEPT_WIDTH'(4);
	localparam logic [KEPT_WIDTH-1:0] KEPT_MAX   = KEPT_WIDTH'(SAMPLE_WIDTH);

	typedef logic [SAMPLE_WIDTH-1:0] pixel_t;
	typedef logic [BYTE_BITS-1:0]    byte_t;
	typedef logic [KEPT_WIDTH-1:0]   kept_t;
	typedef logic [FILL_WIDTH-1:0]   fill_t;

	// one output word
	typedef struct packed {
		byte_t packed_byte;
		logic  final_byte;
	} word_t;

	// what one pixel produces, plus the packer state it leaves
	typedef struct packed {
		logic [1:0] count;
		word_t      w0;
		word_t      w1;
		byte_t      acc;
		fill_t      fill;
	} pack_res_t;

endpackage

// ----- design/qbp_if.sv -----
interface qbp_pix_if;
	import qbp_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel_value;
	logic   last_sample;

	modport source (output valid, output pixel_value, output last_sample, input ready);
	modport sink (input valid, input pixel_value, input last_sample, output ready);
endinterface

interface qbp_byte_if;
	import qbp_pkg::*;

	logic  valid;
	logic  ready;
	byte_t packed_byte;
	logic  final_byte;

	modport source (output valid, output packed_byte, output final_byte, input ready);
	modport sink (input valid, input packed_byte, input final_byte, output ready);
endinterface

interface qbp_cfg_if;
	import qbp_pkg::*;

	logic  valid;
	logic  ready;
	kept_t kept_bits;

	modport source (output valid, output kept_bits, input ready);
	modport sink (input valid, input kept_bits, output ready);
endinterface

// ----- design/qbp_pack.sv -----
module qbp_pack (
	input  qbp_pkg::pixel_t    pixel,
	input  logic               last,
	input  qbp_pkg::kept_t     kept,
	input  qbp_pkg::byte_t     acc,
	input  qbp_pkg::fill_t     fill,
	output qbp_pkg::pack_res_t res
);
	import qbp_pkg::*;

	kept_t                   n;
	kept_t                   shamt;
	pixel_t                  bits;
	logic [2*BYTE_BITS-1:0]  merged;
	logic [KEPT_WIDTH:0]     total;
	logic                    full;
	byte_t                   rem;
	fill_t                   rem_fill;
	logic                    flush;

	always_comb begin
		n        = (kept > KEPT_MAX) ? KEPT_MAX : kept;
		shamt    = KEPT_MAX - n;
		bits     = pixel >> shamt;
		merged   = {{BYTE_BITS{1'b0}}, acc} | ({{BYTE_BITS{1'b0}}, bits} << fill);
		total    = (KEPT_WIDTH+1)'(fill) + (KEPT_WIDTH+1)'(n);
		full     = total >= (KEPT_WIDTH+1)'(BYTE_BITS);
		rem      = full ? merged[2*BYTE_BITS-1:BYTE_BITS] : merged[BYTE_BITS-1:0];
		rem_fill = full ? FILL_WIDTH'(total - (KEPT_WIDTH+1)'(BYTE_BITS))
		                : FILL_WIDTH'(total);
		flush    = last && (rem_fill != '0);

		res.w0.packed_byte = full ? merged[BYTE_BITS-1:0] : rem;
		res.w0.final_byte  = last && !(full && flush);
		res.w1.packed_byte = rem;
		res.w1.final_byte  = 1'b1;

		// a flushed partial word takes the first slot when no byte completed
		res.count = 2'(full) + 2'(flush);
		res.acc   = last ? '0 : rem;
		res.fill  = last ? '0 : rem_fill;
	end

endmodule

// ----- design/quantize_and_bit_pack.sv -----
// Quantiser and LSB-first bit packer for 8-bit pixels.
// pix: pixel words (pixel_value, last_sample) on a valid/ready channel.
// pkd: packed bytes (packed_byte, final_byte) on a valid/ready channel.
// cfg: write channel for kept_bits; always ready, write only while idle.
// Each pixel keeps its top kept_bits bits (values above 8 act as 8), which
// are appended lowest first into a byte; every full byte is sent, and a pixel
// marked last flushes any partial byte zero padded with final_byte set.
// An accepted pixel goes through one input register, then the shift-and-merge
// writes straight into a four-word output queue that drives byte valid.
// Throughput is one pixel per cycle; a pixel may give up to two bytes, and
// the input side waits only while the queue has fewer than two free words.
// When the receiver stalls, bytes collect in the queue and the input
// stops once fewer than two words are free; nothing is dropped.
// Reset clears the packer, empties the queue and sets kept_bits to 4.
module quantize_and_bit_pack (
	input  logic        clk,
	input  logic        arst_n,
	qbp_pix_if.sink     pix,
	qbp_byte_if.source  pkd,
	qbp_cfg_if.sink     cfg
);
	import qbp_pkg::*;

	kept_t                kept_q;
	byte_t                acc_q;
	fill_t                fill_q;

	pixel_t               pixel_s1;
	logic                 last_s1;
	logic                 valid_s1;
	logic                 advance;

	pack_res_t            res;

	word_t                fifo_q [FIFO_DEPTH];
	logic [PTR_WIDTH-1:0] wr_ptr_q;
	logic [PTR_WIDTH-1:0] rd_ptr_q;
	logic [CNT_WIDTH-1:0] count_q;
	logic [1:0]           push_n;
	logic                 pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= KEPT_RESET;
		end else if (cfg.valid) begin
			kept_q <= cfg.kept_bits;
		end
	end

	// room for the worst case of two words per pixel
	assign advance   = valid_s1 && (count_q <= CNT_WIDTH'(FIFO_DEPTH - 2));
	assign pix.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			pixel_s1 <= pix.pixel_value;
			last_s1  <= pix.last_sample;
		end
	end

	qbp_pack u_pack (
		.pixel (pixel_s1),
		.last  (last_s1),
		.kept  (kept_q),
		.acc   (acc_q),
		.fill  (fill_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (advance) begin
			acc_q  <= res.acc;
			fill_q <= res.fill;
		end
	end

	assign push_n = advance ? res.count : 2'd0;
	assign pop    = pkd.valid && pkd.ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res.w0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_WIDTH'(1)] <= res.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_WIDTH'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_WIDTH'(1);
			end
			count_q <= count_q + CNT_WIDTH'(push_n) - CNT_WIDTH'(pop);
		end
	end

	assign pkd.valid       = count_q != '0;
	assign pkd.packed_byte = fifo_q[rd_ptr_q].packed_byte;
	assign pkd.final_byte  = fifo_q[rd_ptr_q].final_byte;

endmodule
